[src/nth_prime_finder_assert.svh]
// Assertion macros shared by the nth_prime_finder RTL files.
`ifndef NTH_PRIME_FINDER_ASSERT_SVH
`define NTH_PRIME_FINDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPF_ASSERT_SAME(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPF_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/npf_pkg.sv]
// Shared types and constants for the n-th prime finder.
package npf_pkg;

	// Fixed widths of the word fields.
	localparam int INDEX_W = 13;
	localparam int PRIME_OUT_W = 16;

	// The search and the trial division both start at two.
	localparam int FIRST_VALUE = 2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_index;
		logic set_err;
		logic init_cand;
		logic next_cand;
		logic count_prime;
		logic rem_start;
		logic next_div;
		logic out_load;
	} npf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic index_bad;
		logic sq_gt_cand;
		logic count_hit;
		logic cand_last;
		logic rem_done;
		logic rem_zero;
		logic out_free;
	} npf_status_t;

endpackage

[src/nth_prime_finder.sv]
// Top level of the n-th prime finder by trial division.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------
//   input   | in_valid  | in_stall  | index
//   output  | out_valid | out_stall | prime, error
//
// One word is searched at a time: each candidate is tested against divisors
// in turn, and each trial division runs in the bit-serial remainder unit. A
// bad index goes straight from the check to the finish state, and its error
// word is loaded once the output register is free; the next word is taken
// back in the idle state.
// Reset clears the controller and the output valid.
// in_stall is high while a search runs; a finished word waits in the output
// register while the next input word is taken.
`include "nth_prime_finder_assert.svh"

module nth_prime_finder #(
	parameter int MAX_INDEX = 4096,
	parameter int PRIME_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [npf_pkg::INDEX_W-1:0]     index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [npf_pkg::PRIME_OUT_W-1:0] prime,
	output logic                            error
);

	import npf_pkg::*;

	npf_cmd_t    cmd;
	npf_status_t status;

	// Search sequencer.
	npf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	// Registers and arithmetic of the search.
	npf_dpath #(
		.MAX_INDEX(MAX_INDEX),
		.PRIME_WIDTH(PRIME_WIDTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.index(index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.prime(prime),
		.error(error)
	);

	// An error word carries a zero prime.
	`NPF_ASSERT_SAME(a_err_zero, clk, arst_n, out_valid && error, prime == '0,
		"error word with nonzero prime")
	// A good word carries a prime of at least two.
	`NPF_ASSERT_SAME(a_prime_min, clk, arst_n, out_valid && !error,
		prime >= PRIME_OUT_W'(FIRST_VALUE), "prime below two")
	// An accepted input word keeps the input stalled in the next cycle.
	`NPF_ASSERT_NEXT(a_busy_after, clk, arst_n, in_valid && !in_stall, in_stall,
		"input not stalled during search")

endmodule

[src/npf_rem.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module npf_rem #(
	parameter int PRIME_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [PRIME_WIDTH-1:0] dividend,
	input  logic [PRIME_WIDTH-1:0] divisor,
	output logic [PRIME_WIDTH-1:0] rem,
	output logic                   done
);

	localparam int CNT_W = $clog2(PRIME_WIDTH + 1);

	logic [PRIME_WIDTH-1:0] rem_q;
	logic [PRIME_WIDTH-1:0] shf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [PRIME_WIDTH:0]   rem_sh;
	logic [PRIME_WIDTH:0]   rem_sub;
	logic [PRIME_WIDTH-1:0] rem_next;

	// Shift in the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		rem_sh = {rem_q, shf_q[PRIME_WIDTH-1]};
		rem_sub = rem_sh - {1'b0, divisor};
		if (rem_sh >= {1'b0, divisor}) begin
			rem_next = rem_sub[PRIME_WIDTH-1:0];
		end else begin
			rem_next = rem_sh[PRIME_WIDTH-1:0];
		end
	end

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(PRIME_WIDTH);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and dividend shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			shf_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			shf_q <= shf_q << 1;
		end
	end

	assign rem = rem_q;
	assign done = done_q;

endmodule

[src/npf_dpath.sv]
// Datapath: index, candidate, divisor, square, prime count and output word.
module npf_dpath #(
	parameter int MAX_INDEX = 4096,
	parameter int PRIME_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  npf_pkg::npf_cmd_t                   cmd,
	output npf_pkg::npf_status_t                status,
	input  logic [npf_pkg::INDEX_W-1:0]         index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [npf_pkg::PRIME_OUT_W-1:0]     prime,
	output logic                                error
);

	import npf_pkg::*;

	localparam int SQ_W = PRIME_WIDTH + 2;
	localparam int EXT_W = PRIME_WIDTH + PRIME_OUT_W;
	localparam logic [INDEX_W-1:0] MAX_IDX = INDEX_W'(MAX_INDEX);
	localparam logic [PRIME_WIDTH-1:0] FIRST_P = PRIME_WIDTH'(FIRST_VALUE);
	localparam logic [SQ_W-1:0] FIRST_SQ = SQ_W'(FIRST_VALUE * FIRST_VALUE);

	logic [INDEX_W-1:0]     index_q;
	logic                   err_q;
	logic [PRIME_WIDTH-1:0] cand_q;
	logic [INDEX_W-1:0]     found_q;
	logic [PRIME_WIDTH-1:0] div_q;
	logic [SQ_W-1:0]        sq_q;
	logic [PRIME_WIDTH-1:0] rem;
	logic                   rem_done;
	logic [EXT_W-1:0]       cand_ext;
	logic                   out_valid_q;
	logic [PRIME_OUT_W-1:0] prime_q;
	logic                   error_q;

	// Serial remainder of candidate by trial divisor.
	npf_rem #(
		.PRIME_WIDTH(PRIME_WIDTH)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.rem_start),
		.dividend(cand_q),
		.divisor(div_q),
		.rem(rem),
		.done(rem_done)
	);

	// Query registers, candidate, divisor and its running square.
	always_ff @(posedge clk) begin
		if (cmd.load_index) begin
			index_q <= index;
			err_q <= 1'b0;
			found_q <= '0;
		end
		if (cmd.set_err) begin
			err_q <= 1'b1;
		end
		if (cmd.count_prime) begin
			found_q <= found_q + INDEX_W'(1);
		end
		if (cmd.init_cand || cmd.next_cand) begin
			div_q <= FIRST_P;
			sq_q <= FIRST_SQ;
		end else if (cmd.next_div) begin
			div_q <= div_q + PRIME_WIDTH'(1);
			sq_q <= sq_q + {1'b0, div_q, 1'b1};
		end
		if (cmd.init_cand) begin
			cand_q <= FIRST_P;
		end else if (cmd.next_cand) begin
			cand_q <= cand_q + PRIME_WIDTH'(1);
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cand_ext = EXT_W'(cand_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			prime_q <= err_q ? '0 : cand_ext[PRIME_OUT_W-1:0];
			error_q <= err_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		status.index_bad = (index_q == '0) || (index_q > MAX_IDX);
		status.sq_gt_cand = sq_q > SQ_W'(cand_q);
		status.count_hit = (found_q + INDEX_W'(1)) == index_q;
		status.cand_last = &cand_q;
		status.rem_done = rem_done;
		status.rem_zero = (rem == '0);
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign prime = prime_q;
	assign error = error_q;

endmodule

[src/npf_ctrl.sv]
// Controller state machine sequencing the candidate search.
`include "nth_prime_finder_assert.svh"

module npf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  npf_pkg::npf_status_t status,
	output npf_pkg::npf_cmd_t    cmd
);

	import npf_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_TEST   = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_index = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.index_bad) begin
					cmd.set_err = 1'b1;
					state_d = ST_FINISH;
				end else begin
					cmd.init_cand = 1'b1;
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				// No divisor left below the square root: the candidate is prime.
				if (status.sq_gt_cand) begin
					cmd.count_prime = 1'b1;
					if (status.count_hit) begin
						state_d = ST_FINISH;
					end else if (status.cand_last) begin
						cmd.set_err = 1'b1;
						state_d = ST_FINISH;
					end else begin
						cmd.next_cand = 1'b1;
					end
				end else begin
					cmd.rem_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.rem_done) begin
					if (!status.rem_zero) begin
						cmd.next_div = 1'b1;
						state_d = ST_TEST;
					end else if (status.cand_last) begin
						cmd.set_err = 1'b1;
						state_d = ST_FINISH;
					end else begin
						cmd.next_cand = 1'b1;
						state_d = ST_TEST;
					end
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// The remainder unit only reports while a division is outstanding.
	`NPF_ASSERT_SAME(a_rem_in_div, clk, arst_n, status.rem_done, state_q == ST_DIV,
		"remainder done outside of division")
	// An output word is only loaded when the output register can take it.
	`NPF_ASSERT_SAME(a_load_free, clk, arst_n, cmd.out_load, status.out_free,
		"output word loaded over a pending word")
	// A started division is still running in the next cycle.
	`NPF_ASSERT_NEXT(a_div_runs, clk, arst_n, cmd.rem_start,
		state_q == ST_DIV && !status.rem_done, "division did not start")

endmodule
